// File: rtl/idnd_pkg.sv
// Shared types and constants for the illumination day/night dimmer.
package idnd_pkg;

  // Operating state of the dimmer.
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_NIGHT = 2'd1,
    MODE_DAY   = 2'd2
  } mode_t;

  // Kind of an input word, carried on s_tuser.
  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_MARK = 1'b1
  } action_t;

  // Light mode codes on the input; every other code is neither.
  localparam logic [1:0] LIGHT_DAY   = 2'd0;
  localparam logic [1:0] LIGHT_NIGHT = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GAUGE   = 2'd0;
  localparam logic [1:0] CFG_DISPLAY = 2'd1;
  localparam logic [1:0] CFG_STARTUP = 2'd2;

  localparam int LEVEL_COUNT   = 5;
  localparam int TABLE_ENTRIES = 5;
  localparam int TABLE_W       = 8 * TABLE_ENTRIES;
  localparam int BRIGHT_W      = 8;
  localparam logic [BRIGHT_W-1:0] DAY_DISPLAY = 8'd100;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

endpackage

// File: rtl/illumination_day_night_dimmer_top.sv
// Top level of the illumination day/night dimmer.
//
// Channel | Direction | Handshake          | Payload
// s       | in        | s_tvalid/s_tready  | s_tdata (levels, mode), s_tuser (action)
// m       | out       | m_tvalid/m_tready  | m_tdata (mode, levels, brightness)
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each word passes an input register and a result register; one word per
// cycle is sustained while m_tready stays high.
// Every input word yields exactly one result word.
// Reset is synchronous: clears both stages and tables, mode off, levels to 1.
// When m_tready is low the result register holds and the input register
// still fills, so one new word is taken during an output stall.
module illumination_day_night_dimmer_top #(
  parameter int LEVEL_COUNT = idnd_pkg::LEVEL_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [0] ignition_on, [2:1] light_mode, [10:3] ui_level, [18:11] nv_level
  input  logic [idnd_pkg::IN_DATA_W-1:0]   s_tdata,
  // [0] action
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [1:0] mode_now, [2] current_valid, [5:3] current_level, [6] gauge_valid,
  // [14:7] gauge_level, [15] display_valid, [23:16] display_level,
  // [24] nv_write_valid, [27:25] nv_write_level
  output logic [idnd_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [idnd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [idnd_pkg::TABLE_W-1:0]     cfg_data
);

  localparam int LVL_BITS = $clog2(LEVEL_COUNT + 1);
  localparam int LVL_W    = (LVL_BITS < 3) ? 3 : LVL_BITS;
  localparam logic [7:0]       LEVEL_MAX8 = 8'(LEVEL_COUNT);
  localparam logic [LVL_W-1:0] LEVEL_MAX  = LVL_W'(LEVEL_COUNT);
  localparam logic [LVL_W-1:0] LEVEL_MIN  = LVL_W'(1);

  // Force a raw level into 1..LEVEL_COUNT.
  function automatic logic [LVL_W-1:0] sat_level(input logic [7:0] v);
    logic [LVL_W-1:0] r;
    if (v == 8'd0) begin
      r = LEVEL_MIN;
    end else if (v > LEVEL_MAX8) begin
      r = LEVEL_MAX;
    end else begin
      r = v[LVL_W-1:0];
    end
    return r;
  endfunction

  // Brightness for a level; entries past the table read as zero.
  function automatic logic [idnd_pkg::BRIGHT_W-1:0] table_pick(
    input logic [idnd_pkg::TABLE_W-1:0] tbl,
    input logic [LVL_W-1:0]             level
  );
    logic [LVL_W-1:0] off;
    logic [2:0]       idx;
    logic [idnd_pkg::BRIGHT_W-1:0] r;
    off = level - LEVEL_MIN;
    idx = off[2:0];
    if (idx < 3'(idnd_pkg::TABLE_ENTRIES)) begin
      r = tbl[{idx, 3'b000} +: idnd_pkg::BRIGHT_W];
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Configuration and state registers.
  logic [idnd_pkg::TABLE_W-1:0] gauge_table;
  logic [idnd_pkg::TABLE_W-1:0] display_table;
  idnd_pkg::mode_t  mode_state, mode_state_next;
  logic [LVL_W-1:0] active_level, active_level_next;
  logic [LVL_W-1:0] stored_level, stored_level_next;
  logic             ui_pending, ui_pending_next;

  // Input stage.
  logic             in_valid;
  logic             in_action;
  logic             in_ign;
  logic [1:0]       in_lmode;
  logic [7:0]       in_ui;
  logic [7:0]       in_nv;

  // Result stage.
  logic                            out_valid;
  logic [idnd_pkg::OUT_DATA_W-1:0] out_data;

  logic adv_out;
  logic take_in;

  // Configuration waits while a word sits in the input register, so a
  // register write never meets a state update.
  assign adv_out   = !out_valid || m_tready;
  assign s_tready  = !in_valid || adv_out;
  assign take_in   = s_tvalid && s_tready;
  assign cfg_ready = !in_valid;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // Step logic for the word in the input register.
  logic             pub_cur, pub_lamps, pub_day, pub_off;
  logic             nv_wr;
  logic [LVL_W-1:0] nv_lvl;
  logic             is_night, leave;
  logic [LVL_W-1:0] fresh;

  always_comb begin
    mode_state_next   = mode_state;
    active_level_next = active_level;
    stored_level_next = stored_level;
    ui_pending_next   = ui_pending;
    pub_cur   = 1'b0;
    pub_lamps = 1'b0;
    pub_day   = 1'b0;
    pub_off   = 1'b0;
    nv_wr     = 1'b0;
    nv_lvl    = '0;
    is_night  = (mode_state == idnd_pkg::MODE_NIGHT);
    leave     = is_night ? (in_lmode != idnd_pkg::LIGHT_NIGHT)
                         : (in_lmode != idnd_pkg::LIGHT_DAY);
    fresh     = sat_level(in_nv);
    if (in_action == idnd_pkg::ACT_MARK) begin
      ui_pending_next = 1'b1;
    end else begin
      case (mode_state)
        idnd_pkg::MODE_OFF: begin
          if (in_ign) begin
            if (in_lmode == idnd_pkg::LIGHT_NIGHT) begin
              mode_state_next = idnd_pkg::MODE_NIGHT;
              pub_lamps       = 1'b1;
            end else begin
              mode_state_next = idnd_pkg::MODE_DAY;
              pub_day         = 1'b1;
            end
          end
        end
        default: begin
          if (!in_ign) begin
            // Leaving for off: write the level back if it moved.
            if (stored_level != active_level) begin
              nv_wr             = 1'b1;
              nv_lvl            = active_level;
              stored_level_next = active_level;
            end
            mode_state_next = idnd_pkg::MODE_OFF;
            pub_cur         = 1'b1;
            pub_off         = 1'b1;
          end else if (leave) begin
            if (is_night) begin
              mode_state_next = idnd_pkg::MODE_DAY;
              pub_day         = 1'b1;
            end else begin
              mode_state_next = idnd_pkg::MODE_NIGHT;
              pub_lamps       = 1'b1;
            end
          end else if (ui_pending) begin
            active_level_next = sat_level(in_ui);
            ui_pending_next   = 1'b0;
            pub_cur           = 1'b1;
            pub_lamps         = is_night;
          end else begin
            stored_level_next = fresh;
            if (fresh != stored_level) begin
              active_level_next = fresh;
              pub_cur           = 1'b1;
              pub_lamps         = is_night;
            end
          end
        end
      endcase
    end
  end

  // Result word assembly.
  logic [idnd_pkg::OUT_DATA_W-1:0] result;
  logic [idnd_pkg::BRIGHT_W-1:0]   gauge_lvl, display_lvl;
  logic [2:0]                      cur_lvl;

  always_comb begin
    gauge_lvl   = pub_lamps ? table_pick(gauge_table, active_level_next) : '0;
    display_lvl = pub_lamps ? table_pick(display_table, active_level_next)
                : (pub_day ? idnd_pkg::DAY_DISPLAY : '0);
    cur_lvl     = pub_cur ? active_level_next[2:0] : 3'd0;
    result      = '0;
    result[1:0]   = mode_state_next;
    result[2]     = pub_cur;
    result[5:3]   = cur_lvl;
    result[6]     = pub_lamps || pub_day || pub_off;
    result[14:7]  = gauge_lvl;
    result[15]    = pub_lamps || pub_day || pub_off;
    result[23:16] = display_lvl;
    result[24]    = nv_wr;
    result[27:25] = nv_lvl[2:0];
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (take_in) begin
      in_action <= s_tuser;
      in_ign    <= s_tdata[0];
      in_lmode  <= s_tdata[2:1];
      in_ui     <= s_tdata[10:3];
      in_nv     <= s_tdata[18:11];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= in_valid;
    end
    if (adv_out && in_valid) begin
      out_data <= result;
    end
  end

  // State update on each step, or a configuration write when no word waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      gauge_table   <= '0;
      display_table <= '0;
      mode_state    <= idnd_pkg::MODE_OFF;
      active_level  <= LEVEL_MIN;
      stored_level  <= LEVEL_MIN;
      ui_pending    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        idnd_pkg::CFG_GAUGE:   gauge_table   <= cfg_data;
        idnd_pkg::CFG_DISPLAY: display_table <= cfg_data;
        idnd_pkg::CFG_STARTUP: begin
          active_level <= sat_level({5'd0, cfg_data[2:0]});
          stored_level <= sat_level({5'd0, cfg_data[2:0]});
        end
        default: begin
        end
      endcase
    end else if (adv_out && in_valid) begin
      mode_state   <= mode_state_next;
      active_level <= active_level_next;
      stored_level <= stored_level_next;
      ui_pending   <= ui_pending_next;
    end
  end

endmodule

// File: rtl/idnd_checker.sv
// Port-level checks for the illumination day/night dimmer, bound to the top.
module idnd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [idnd_pkg::OUT_DATA_W-1:0] m_tdata
);

  // A stalled result word holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed during stall");

  // Nothing is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // A write-back only happens on the way to off, with lamps dark.
  a_wb_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[24] |->
      m_tdata[1:0] == idnd_pkg::MODE_OFF && m_tdata[15] && m_tdata[23:16] == 8'd0 &&
      m_tdata[2])
    else $error("write-back outside of switch-off");

  // In day mode, published lamps are gauge dark and display at day level.
  a_day_lamps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == idnd_pkg::MODE_DAY && m_tdata[15] |->
      m_tdata[23:16] == idnd_pkg::DAY_DISPLAY && m_tdata[14:7] == 8'd0)
    else $error("day lamps published with wrong values");

endmodule

bind illumination_day_night_dimmer_top idnd_checker u_idnd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/tb_illumination_day_night_dimmer_top.sv
// Self-checking testbench for the illumination day/night dimmer top level.
module tb_illumination_day_night_dimmer_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package does not name.
  localparam logic [idnd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [1:0] LIGHT_ALT2 = 2'd2;
  localparam logic [1:0] LIGHT_ALT3 = 2'd3;
  localparam logic IGN_OFF = 1'b0;
  localparam logic IGN_ON  = 1'b1;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // One result word as it sits in m_tdata, lowest field last.
  typedef struct packed {
    logic [2:0] nv_write_level;
    logic       nv_write_valid;
    logic [7:0] display_level;
    logic       display_valid;
    logic [7:0] gauge_level;
    logic       gauge_valid;
    logic [2:0] current_level;
    logic       current_valid;
    logic [1:0] mode_now;
  } dim_word_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  // [0] ignition_on, [2:1] light_mode, [10:3] ui_level, [18:11] nv_level
  logic [idnd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  // [0] action
  logic                            s_tuser = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // [1:0] mode_now, [2] current_valid, [5:3] current_level, [6] gauge_valid,
  // [14:7] gauge_level, [15] display_valid, [23:16] display_level,
  // [24] nv_write_valid, [27:25] nv_write_level
  logic [idnd_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [idnd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [idnd_pkg::TABLE_W-1:0]    cfg_data = '0;

  illumination_day_night_dimmer_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted dimmer state and registers.
  idnd_pkg::mode_t              dim_mode = idnd_pkg::MODE_OFF;
  logic [2:0]                   lvl_active = 3'd1;
  logic [2:0]                   lvl_stored = 3'd1;
  logic                         ui_mark_pending = 1'b0;
  logic [idnd_pkg::TABLE_W-1:0] gauge_tbl = '0;
  logic [idnd_pkg::TABLE_W-1:0] display_tbl = '0;

  dim_word_t expected_words[$];
  int        mismatches = 0;
  int        send_gap_max = 11;
  int        recv_gap_max = 11;
  int        recv_hold = 0;
  int        stall_cycles = 0;

  // Scenario state for the random sequences.
  logic       sc_ign = IGN_ON;
  logic [1:0] sc_light = idnd_pkg::LIGHT_NIGHT;
  logic [7:0] sc_nv = 8'd1;

  // Force a level into 1..LEVEL_COUNT.
  function automatic logic [2:0] clamp_level(logic [7:0] v);
    if (v == 8'd0) return 3'd1;
    if (v > idnd_pkg::LEVEL_COUNT) return 3'(idnd_pkg::LEVEL_COUNT);
    return v[2:0];
  endfunction

  // Brightness for a level; levels past the table read as zero.
  function automatic logic [7:0] table_entry(logic [idnd_pkg::TABLE_W-1:0] tbl,
                                             logic [2:0] lvl);
    logic [2:0] idx;
    idx = lvl - 3'd1;
    if (idx >= idnd_pkg::TABLE_ENTRIES) return 8'd0;
    return tbl[8*idx +: 8];
  endfunction

  // Advance the predicted state by one input word and return the result word.
  function automatic dim_word_t dimmer_predict(idnd_pkg::action_t act, logic ign,
                                               logic [1:0] lmode, logic [7:0] ui,
                                               logic [7:0] nv);
    dim_word_t  r;
    logic       show_cur, show_lamps, day_lamps, in_night, leave;
    logic [2:0] fresh;
    r = '0;
    show_cur = 1'b0;
    show_lamps = 1'b0;
    day_lamps = 1'b0;
    if (act == idnd_pkg::ACT_MARK) begin
      ui_mark_pending = 1'b1;
    end else if (dim_mode == idnd_pkg::MODE_OFF) begin
      if (ign) begin
        if (lmode == idnd_pkg::LIGHT_NIGHT) begin
          dim_mode = idnd_pkg::MODE_NIGHT;
          show_lamps = 1'b1;
        end else begin
          dim_mode = idnd_pkg::MODE_DAY;
          day_lamps = 1'b1;
        end
      end
    end else if (!ign) begin
      // Shutdown writes the level back only when it moved.
      if (lvl_stored != lvl_active) begin
        r.nv_write_valid = 1'b1;
        r.nv_write_level = lvl_active;
        lvl_stored = lvl_active;
      end
      dim_mode = idnd_pkg::MODE_OFF;
      show_cur = 1'b1;
      r.gauge_valid = 1'b1;
      r.display_valid = 1'b1;
    end else begin
      in_night = (dim_mode == idnd_pkg::MODE_NIGHT);
      leave = in_night ? (lmode != idnd_pkg::LIGHT_NIGHT) : (lmode != idnd_pkg::LIGHT_DAY);
      if (leave) begin
        if (in_night) begin
          dim_mode = idnd_pkg::MODE_DAY;
          day_lamps = 1'b1;
        end else begin
          dim_mode = idnd_pkg::MODE_NIGHT;
          show_lamps = 1'b1;
        end
      end else if (ui_mark_pending) begin
        lvl_active = clamp_level(ui);
        ui_mark_pending = 1'b0;
        show_cur = 1'b1;
        show_lamps = in_night;
      end else begin
        fresh = clamp_level(nv);
        if (fresh != lvl_stored) begin
          lvl_active = fresh;
          show_cur = 1'b1;
          show_lamps = in_night;
        end
        lvl_stored = fresh;
      end
    end
    if (day_lamps) begin
      r.gauge_valid = 1'b1;
      r.display_valid = 1'b1;
      r.display_level = idnd_pkg::DAY_DISPLAY;
    end
    if (show_cur) begin
      r.current_valid = 1'b1;
      r.current_level = lvl_active;
    end
    if (show_lamps) begin
      r.gauge_valid = 1'b1;
      r.gauge_level = table_entry(gauge_tbl, lvl_active);
      r.display_valid = 1'b1;
      r.display_level = table_entry(display_tbl, lvl_active);
    end
    r.mode_now = dim_mode;
    return r;
  endfunction

  function automatic string word_text(dim_word_t w);
    return $sformatf("mode=%0d cur=%0b/%0d gauge=%0b/%0d disp=%0b/%0d nvw=%0b/%0d",
                     w.mode_now, w.current_valid, w.current_level, w.gauge_valid,
                     w.gauge_level, w.display_valid, w.display_level, w.nv_write_valid,
                     w.nv_write_level);
  endfunction

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", what);
  endfunction

  // Mostly small levels so saturation and every table entry are hit often.
  function automatic logic [7:0] level_byte();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one input word after a random gap and record its prediction.
  task automatic send_word(idnd_pkg::action_t act, logic ign, logic [1:0] lmode,
                           logic [7:0] ui, logic [7:0] nv);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {5'd0, nv, ui, lmode, ign};
    do @(posedge clk); while (!s_tready);
    expected_words.push_back(dimmer_predict(act, ign, lmode, ui, nv));
  endtask

  // Stop offering and let every outstanding word drain.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [idnd_pkg::CFG_IDX_W-1:0] idx,
                           logic [idnd_pkg::TABLE_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      idnd_pkg::CFG_GAUGE:   gauge_tbl = value;
      idnd_pkg::CFG_DISPLAY: display_tbl = value;
      idnd_pkg::CFG_STARTUP: begin
        lvl_active = clamp_level({5'd0, value[2:0]});
        lvl_stored = lvl_active;
      end
      default: ;
    endcase
  endtask

  function automatic logic [idnd_pkg::TABLE_W-1:0] random_table();
    return {8'($urandom_range(0, 255)), 32'($urandom)};
  endfunction

  task automatic tick(logic ign, logic [1:0] lmode, logic [7:0] ui, logic [7:0] nv);
    send_word(idnd_pkg::ACT_TICK, ign, lmode, ui, nv);
  endtask

  task automatic mark(logic [7:0] ui);
    send_word(idnd_pkg::ACT_MARK, IGN_ON, idnd_pkg::LIGHT_NIGHT, ui, 8'd0);
  endtask

  // Enter night, walk the UI level through every value 0..7, then shut down.
  task automatic sweep_levels();
    tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'd0, sc_nv);
    for (int lvl = 0; lvl < 8; lvl++) begin
      mark(8'(lvl));
      tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'(lvl), sc_nv);
    end
    tick(IGN_OFF, idnd_pkg::LIGHT_NIGHT, 8'd0, sc_nv);
  endtask

  // Well-formed drive cycles with random content, plus some noise words.
  task automatic random_items(int count);
    int roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_word($urandom_range(0, 1) != 0 ? idnd_pkg::ACT_MARK : idnd_pkg::ACT_TICK,
                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (roll < 18) begin
        send_word(idnd_pkg::ACT_MARK, sc_ign, sc_light, level_byte(), sc_nv);
      end else begin
        if (sc_ign) begin
          if ($urandom_range(0, 99) < 4) sc_ign = IGN_OFF;
        end else if ($urandom_range(0, 99) < 40) begin
          sc_ign = IGN_ON;
        end
        if ($urandom_range(0, 99) < 8) sc_light = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 15) sc_nv = level_byte();
        tick(sc_ign, sc_light, level_byte(), sc_nv);
      end
    end
  endtask

  // A few words on the reset register values.
  task automatic test_reset_defaults();
    tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'd0, 8'd1);
    mark(8'd4);
    tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'd4, 8'd1);
    tick(IGN_OFF, idnd_pkg::LIGHT_DAY, 8'd0, 8'd1);
  endtask

  // Every state transition, field extremes and saturation.
  task automatic test_mode_transitions();
    write_reg(idnd_pkg::CFG_GAUGE, 40'hFF_44_33_22_11);
    write_reg(idnd_pkg::CFG_DISPLAY, 40'h01_80_40_20_0A);
    write_reg(idnd_pkg::CFG_STARTUP, 40'd3);
    mark(8'd2);
    tick(IGN_OFF, idnd_pkg::LIGHT_NIGHT, 8'd0, 8'd3);
    tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'd0, 8'd3);
    tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'd0, 8'd3);
    mark(8'd255);
    tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'd255, 8'd3);
    tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'd0, 8'd0);
    tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'd0, 8'd0);
    tick(IGN_ON, idnd_pkg::LIGHT_NIGHT, 8'd0, 8'd255);
    tick(IGN_ON, LIGHT_ALT2, 8'd0, 8'd255);
    tick(IGN_ON, idnd_pkg::LIGHT_DAY, 8'd0, 8'd255);
    mark(8'd2);
    tick(IGN_ON, idnd_pkg::LIGHT_DAY, 8'd2, 8'd255);
    tick(IGN_ON, idnd_pkg::LIGHT_DAY, 8'd0, 8'd4);
    mark(8'd1);
    tick(IGN_ON, idnd_pkg::LIGHT_DAY, 8'd1, 8'd4);
    tick(IGN_ON, LIGHT_ALT3, 8'd0, 8'd4);
    tick(IGN_OFF, idnd_pkg::LIGHT_NIGHT, 8'd0, 8'd4);
    tick(IGN_ON, LIGHT_ALT2, 8'd0, 8'd4);
    tick(IGN_OFF, idnd_pkg::LIGHT_DAY, 8'd0, 8'd4);
    tick(IGN_ON, LIGHT_ALT3, 8'd0, 8'd4);
    mark(8'd7);
    tick(IGN_ON, LIGHT_ALT3, 8'd7, 8'd4);
    tick(IGN_OFF, LIGHT_ALT3, 8'd255, 8'd255);
  endtask

  // Startup saturation, unused index and table extremes.
  task automatic test_register_extremes();
    write_reg(idnd_pkg::CFG_GAUGE, '1);
    write_reg(idnd_pkg::CFG_DISPLAY, '0);
    write_reg(idnd_pkg::CFG_STARTUP, 40'd0);
    sweep_levels();
    write_reg(idnd_pkg::CFG_GAUGE, '0);
    write_reg(idnd_pkg::CFG_DISPLAY, '1);
    write_reg(idnd_pkg::CFG_STARTUP, 40'd7);
    sweep_levels();
    write_reg(idnd_pkg::CFG_STARTUP, {37'h1F_FFFF_FFFF, 3'd6});
    sweep_levels();
    write_reg(CFG_UNUSED, random_table());
    write_reg(CFG_UNUSED, '1);
    write_reg(idnd_pkg::CFG_STARTUP, 40'd5);
    sweep_levels();
  endtask

  // Receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    send_gap_max = 0;
    recv_hold = 80;
    sc_ign = IGN_ON;
    random_items(24);
    wait_idle();
    send_gap_max = 11;
  endtask

  // Sender drains the block completely in the middle of a sequence.
  task automatic test_sender_pause();
    random_items(20);
    wait_idle();
    random_items(20);
  endtask

  // Random phases, each with its own registers and idle pattern.
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(idnd_pkg::CFG_GAUGE,
                phase == 0 ? '1 : (phase == 1 ? '0 : random_table()));
      write_reg(idnd_pkg::CFG_DISPLAY,
                phase == 1 ? '1 : (phase == 0 ? '0 : random_table()));
      write_reg(idnd_pkg::CFG_STARTUP, random_table());
      send_gap_max = (phase % 3 == 1) ? 0 : 11;
      recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      random_items(85);
    end
    recv_gap_max = 11;
    send_gap_max = 11;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_mode_transitions();
    test_register_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_phases();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("illumination_day_night_dimmer_top: match");
    end else begin
      $display("illumination_day_night_dimmer_top: mismatch");
    end
    $finish;
  end

  // Receiver: random stalls per word, and a long hold when a test asks.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (recv_hold > 0) begin
        m_tready <= 1'b0;
        repeat (recv_hold) @(posedge clk);
        recv_hold = 0;
      end
      stall = $urandom_range(0, recv_gap_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    dim_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = dim_word_t'(m_tdata[27:0]);
      if (expected_words.size() == 0) begin
        report_mismatch({"unexpected word: ", word_text(got)});
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          report_mismatch({"expected ", word_text(want), "\n  actual ", word_text(got)});
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
    begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("illumination_day_night_dimmer_top: mismatch");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
rtl/idnd_pkg.sv
rtl/illumination_day_night_dimmer_top.sv
rtl/idnd_checker.sv
tb/tb_illumination_day_night_dimmer_top.sv
